// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the timer RTL.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checking disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// Next-cycle implication, checking disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

// File: hw/rtl/pit_pkg.sv
// Shared types and constants for the periodic interrupt timer.
// No dependencies; used by pit_channel and periodic_interrupt_timer.
package pit_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int WORD_W          = 32;
    localparam int LINES           = 4;

    // Bit positions inside written data
    localparam int CTRL_RUN_BIT = 0;
    localparam int CTRL_IE_BIT  = 1;
    localparam int FLAG_CLR_BIT = 0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEL_LOAD  = 2'd0,
        SEL_COUNT = 2'd1,
        SEL_CTRL  = 2'd2,
        SEL_FLAG  = 2'd3
    } sel_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        channel;
        logic [1:0]        reg_select;
        logic [WORD_W-1:0] write_data;
    } pit_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [LINES-1:0]  irq_lines;
        logic [LINES-1:0]  timeout_flags;
    } pit_out_t;

    // Per-channel command, at most one action set per cycle
    typedef struct packed {
        logic              tick;
        logic              wr_load;
        logic              wr_ctrl;
        logic              clr_flag;
        logic              run_set;
        logic              ie_set;
        logic [WORD_W-1:0] data;
    } chan_cmd_t;

    // Per-channel status, values zero-extended to a word
    typedef struct packed {
        logic [WORD_W-1:0] load;
        logic [WORD_W-1:0] count;
        logic              run;
        logic              ie;
        logic              flag;
        logic              flag_next;
    } chan_stat_t;

endpackage

// File: hw/rtl/pit_channel.sv
// One count-down channel: load value, counter, run/irq-enable and timeout flag.
// Depends on pit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pit_channel #(
    parameter int COUNT_WIDTH = pit_pkg::COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pit_pkg::chan_cmd_t  cmd,
    output pit_pkg::chan_stat_t stat
);

    localparam int WW = pit_pkg::WORD_W;

    logic [COUNT_WIDTH-1:0] load_reg, load_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   run_reg, run_next;
    logic                   ie_reg, ie_next;
    logic                   flag_reg, flag_next;

    // Next-state for tick, load write, control and flag actions
    always_comb begin
        load_next  = load_reg;
        count_next = count_reg;
        run_next   = run_reg;
        ie_next    = ie_reg;
        flag_next  = flag_reg;
        if (cmd.tick && run_reg) begin
            if (count_reg == '0) begin
                flag_next  = 1'b1;
                count_next = load_reg;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.wr_load) begin
            load_next = cmd.data[COUNT_WIDTH-1:0];
        end
        if (cmd.wr_ctrl) begin
            // starting a stopped channel reloads it
            if (cmd.run_set && !run_reg) begin
                count_next = load_reg;
            end
            run_next = cmd.run_set;
            ie_next  = cmd.ie_set;
        end
        if (cmd.clr_flag) begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg  <= '0;
            count_reg <= '0;
            run_reg   <= 1'b0;
            ie_reg    <= 1'b0;
            flag_reg  <= 1'b0;
        end else begin
            load_reg  <= load_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            ie_reg    <= ie_next;
            flag_reg  <= flag_next;
        end
    end

    assign stat.load      = WW'(load_reg);
    assign stat.count     = WW'(count_reg);
    assign stat.run       = run_reg;
    assign stat.ie        = ie_reg;
    assign stat.flag      = flag_reg;
    assign stat.flag_next = flag_next;

    // Expiry of a running channel raises its flag
    `ASSERT_NEXT(a_expiry_flags, aclk, aresetn,
        cmd.tick && run_reg && (count_reg == '0), flag_reg)
    // A start copies the load value into the counter
    `ASSERT_NEXT(a_start_reload, aclk, aresetn,
        cmd.wr_ctrl && cmd.run_set && !run_reg, count_reg == $past(load_reg))
    // A stopped channel's counter does not move on a tick
    `ASSERT_NEXT(a_stopped_hold, aclk, aresetn,
        cmd.tick && !run_reg && !cmd.wr_ctrl, count_reg == $past(count_reg))

endmodule

// File: hw/rtl/periodic_interrupt_timer.sv
// Periodic interrupt timer top level: channel array, input stage, result register.
// Depends on pit_pkg, pit_channel and assert_macros.svh.
//
// Usage:
//   s_valid/s_ready/s_payload carry one transaction per item: a tick, a register
//   write or a register read (channel, reg_select, write_data). Every accepted
//   transaction produces exactly one result on m_valid/m_ready/m_payload:
//   read_data (zero unless a read), irq_lines and timeout_flags after the item.
//   cfg_wr_en/cfg_wr_data write module_enable; with it low, ticks are ignored.
// Timing:
//   One item per cycle sustained while m_ready is high. A transaction is held
//   in the input register, where the channel registers are updated and the
//   result formed; the result register then presents it on m_payload.
// Stall:
//   While m_ready is low one further transaction is held in the input
//   register; after that s_ready drops until the result is taken.
// Reset:
//   aresetn (synchronous, active low) clears all channels, flags, the module
//   enable and both pipeline valids; no items are in flight afterwards.
`include "assert_macros.svh"

module periodic_interrupt_timer #(
    parameter int CHANNELS    = pit_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = pit_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  pit_pkg::pit_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pit_pkg::pit_out_t m_payload
);

    localparam int WW    = pit_pkg::WORD_W;
    localparam int LINES = pit_pkg::LINES;
    localparam int NV    = (CHANNELS > LINES) ? CHANNELS : LINES;

    logic              enable_reg;
    logic              in_valid_reg, in_valid_next;
    pit_pkg::pit_in_t  in_reg;
    logic              out_valid_reg, out_valid_next;
    pit_pkg::pit_out_t out_reg, out_next;
    logic              fire;
    logic              s_take;

    pit_pkg::chan_cmd_t  cmd  [CHANNELS];
    pit_pkg::chan_stat_t stat [CHANNELS];

    logic [CHANNELS-1:0] flag_vec, flag_now_vec, ie_vec;
    logic [NV-1:0]       flag_wide, ie_wide;
    logic [WW-1:0]       rd_data;

    // Pipeline handshake
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Decode the held transaction into per-channel commands
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            logic hit;
            hit = fire && (32'(in_reg.channel) == c)
                && (in_reg.opcode == pit_pkg::OP_WRITE);
            cmd[c].tick     = fire && enable_reg && (in_reg.opcode == pit_pkg::OP_TICK);
            cmd[c].wr_load  = hit && (in_reg.reg_select == pit_pkg::SEL_LOAD);
            cmd[c].wr_ctrl  = hit && (in_reg.reg_select == pit_pkg::SEL_CTRL);
            cmd[c].clr_flag = hit && (in_reg.reg_select == pit_pkg::SEL_FLAG)
                && in_reg.write_data[pit_pkg::FLAG_CLR_BIT];
            cmd[c].run_set  = in_reg.write_data[pit_pkg::CTRL_RUN_BIT];
            cmd[c].ie_set   = in_reg.write_data[pit_pkg::CTRL_IE_BIT];
            cmd[c].data     = in_reg.write_data;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        pit_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[g]),
            .stat    (stat[g])
        );
    end

    // Read mux and line vectors
    always_comb begin
        rd_data = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            flag_vec[c]     = stat[c].flag_next;
            flag_now_vec[c] = stat[c].flag;
            ie_vec[c]       = stat[c].ie;
            if ((in_reg.opcode == pit_pkg::OP_READ) && (32'(in_reg.channel) == c)) begin
                unique case (in_reg.reg_select)
                    pit_pkg::SEL_LOAD:  rd_data = stat[c].load;
                    pit_pkg::SEL_COUNT: rd_data = stat[c].count;
                    pit_pkg::SEL_CTRL:  rd_data = {{(WW-2){1'b0}}, stat[c].ie, stat[c].run};
                    pit_pkg::SEL_FLAG:  rd_data = {{(WW-1){1'b0}}, stat[c].flag};
                endcase
            end
        end
    end

    assign flag_wide = NV'(flag_vec);
    assign ie_wide   = NV'(ie_vec);

    // Interrupt enables are unchanged by reads and ticks; after a control
    // write use the new value, taken from the written data for that channel.
    always_comb begin
        logic [NV-1:0] ie_after;
        ie_after = ie_wide;
        if ((in_reg.opcode == pit_pkg::OP_WRITE)
            && (in_reg.reg_select == pit_pkg::SEL_CTRL)
            && (32'(in_reg.channel) < CHANNELS)) begin
            ie_after[in_reg.channel] = in_reg.write_data[pit_pkg::CTRL_IE_BIT];
        end
        out_next.read_data     = rd_data;
        out_next.timeout_flags = flag_wide[LINES-1:0];
        out_next.irq_lines     = flag_wide[LINES-1:0] & ie_after[LINES-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_payload;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // A waiting result and a held item block the input side
    `ASSERT_IMPLY(a_no_overrun, aclk, aresetn,
        out_valid_reg && !m_ready && in_valid_reg, !s_ready)
    // Ticks with the module frozen leave every flag as it was
    `ASSERT_NEXT(a_frozen_flags, aclk, aresetn,
        fire && !enable_reg && (in_reg.opcode == pit_pkg::OP_TICK),
        flag_now_vec == $past(flag_now_vec))
    // A read changes no flag
    `ASSERT_NEXT(a_read_flags, aclk, aresetn,
        fire && (in_reg.opcode == pit_pkg::OP_READ),
        flag_now_vec == $past(flag_now_vec))

endmodule
